### rtl/newton_fractal_pixel_top_macros.svh
// ----------------------------------------------------------------------------
// Newton fractal pixel engine: assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef NEWTON_FRACTAL_PIXEL_TOP_MACROS_SVH
`define NEWTON_FRACTAL_PIXEL_TOP_MACROS_SVH

// same-cycle implication
`define NFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/nfp_pkg.sv
// ----------------------------------------------------------------------------
// Newton fractal pixel package
// Q16.32 constants, saturation helpers, register indexes and sequencer codes.
// ----------------------------------------------------------------------------
package nfp_pkg;

  localparam int Q_W = 48;
  localparam int W_W = 52;  // headroom for sums of a few Q values

  localparam logic signed [Q_W-1:0] QMAX  = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [Q_W-1:0] QMIN  = 48'sh8000_0000_0000;
  localparam logic signed [Q_W-1:0] EPS_Q = 48'sd4295;       // 1e-6
  localparam logic [Q_W-1:0]        RCP_MIN_DEN = 48'h2_0000; // 2^17

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_RE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_IM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 3'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_SETUP,
    ST_MAP_DIV,
    ST_MAP_WB,
    ST_HEAD,
    ST_MUL_LOAD,
    ST_MUL_RUN,
    ST_MUL_WB,
    ST_RCP_SETUP,
    ST_RCP_DIV,
    ST_RCP_WB,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    STP_AA,
    STP_BB,
    STP_SS,
    STP_AB,
    STP_AT,
    STP_BT,
    STP_NA,
    STP_NB,
    STP_DR,
    STP_DI
  } step_e;

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [W_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > W_W'(QMAX)) r = QMAX;
    else if (v < W_W'(QMIN)) r = QMIN;
    else r = v[Q_W-1:0];
    return r;
  endfunction

  function automatic logic [Q_W-1:0] mag_q(input logic signed [Q_W-1:0] v);
    return v[Q_W-1] ? Q_W'(-v) : Q_W'(v);
  endfunction

  // sign and 64-bit magnitude to saturated Q value
  function automatic logic signed [Q_W-1:0] from_mag(input logic neg, input logic [63:0] m);
    logic signed [Q_W-1:0] r;
    if (neg) begin
      if (m >= 64'h8000_0000_0000) r = QMIN;
      else r = -$signed(m[Q_W-1:0]);
    end else begin
      if (m > 64'h7FFF_FFFF_FFFF) r = QMAX;
      else r = $signed(m[Q_W-1:0]);
    end
    return r;
  endfunction

endpackage

### rtl/newton_fractal_pixel_top.sv
// ----------------------------------------------------------------------------
// Newton fractal pixel engine
// Iteration count and color level of z^3-1 Newton steps for one pixel.
// ----------------------------------------------------------------------------
// Usage: one pixel enters on the s_axis channel (tdata: pixel_x, pixel_y).
// The view is set through the cfg write port while the block is idle:
// index 0 center_re, 1 center_im, 2 zoom, 3 max_iterations.
// One result leaves on m_axis (tdata: iteration_count, color_level).
// The block works on one item at a time; s_axis_tready is high only
// when idle. Each coordinate mapping runs the shared 64-step restoring
// divider; each Newton pass runs up to ten products on the shared 24x24
// multiplier plus, unless the denominator is at or below RCP_MIN_DEN,
// one reciprocal on the divider.
// The result is held on m_axis until taken; a stalled receiver keeps the
// block busy. Reset returns to idle and loads center 0, zoom 1.0 and an
// iteration limit of 50.
`include "newton_fractal_pixel_top_macros.svh"

module newton_fractal_pixel_top
  import nfp_pkg::*;
#(
  parameter int IMAGE_WIDTH  = 1024,
  parameter int IMAGE_HEIGHT = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,   // pixel_x[9:0], pixel_y[19:10]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata,   // iteration_count[15:0], color_level[23:16]
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int DIM_MAX = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
  localparam int DIM_W   = $clog2(DIM_MAX + 1);
  localparam int OFF_W   = ((DIM_W > 10) ? DIM_W : 10) + 1;
  localparam logic signed [OFF_W-1:0] HALF_X = OFF_W'(IMAGE_WIDTH / 2);
  localparam logic signed [OFF_W-1:0] HALF_Y = OFF_W'(IMAGE_HEIGHT / 2);
  localparam logic [DIM_W-1:0] SIZE_X = DIM_W'(IMAGE_WIDTH);
  localparam logic [DIM_W-1:0] SIZE_Y = DIM_W'(IMAGE_HEIGHT);

  // configuration
  logic signed [Q_W-1:0] center_re_q, center_im_q;
  logic [31:0]           zoom_q;
  logic [15:0]           max_iter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_re_q <= '0;
      center_im_q <= '0;
      zoom_q      <= 32'd65536;
      max_iter_q  <= 16'd50;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_CENTER_RE: center_re_q <= $signed(cfg_wdata_i);
        REG_CENTER_IM: center_im_q <= $signed(cfg_wdata_i);
        REG_ZOOM:      zoom_q      <= cfg_wdata_i[31:0];
        REG_MAX_ITER:  max_iter_q  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // control
  state_e      state_q, state_d;
  step_e       step_q, step_d;
  logic        map_y_q;
  logic [15:0] count_q;
  logic [5:0]  div_cnt_q;
  logic [1:0]  mul_cnt_q;

  // payload
  logic [9:0]            px_q, py_q;
  logic signed [Q_W-1:0] a_q, b_q, aa_q, bb_q, s_q, t_q, ab_q;
  logic signed [Q_W-1:0] nre_q, nim_q, rcp_q, na_q, nb_q, dd_q;
  logic                  map_neg_q;

  // shared multiplier
  logic [Q_W-1:0]        mx_q, my_q;
  logic                  mneg_q;
  logic [2*Q_W-1:0]      acc_q;
  logic [47:0]           pp;
  logic [2*Q_W-1:0]      pp_sh;
  logic signed [Q_W-1:0] mul_res;
  logic signed [Q_W-1:0] op_x, op_y;

  // shared divider
  logic [63:0]    div_num_q;
  logic [Q_W-1:0] div_rem_q, div_den_q;
  logic [Q_W:0]   rem_sh;
  logic           div_ge;

  // misc combinational
  logic signed [Q_W-1:0] dr, di, sq_dist, den3, map_val, center_sel;
  logic signed [OFF_W-1:0] off;
  logic [OFF_W-1:0]      off_mag;
  logic [31:0]           zoom_eff;
  logic [31+DIM_W:0]     map_div;
  logic [16:0]           count_inc;
  logic [63:0]           rcp_quo;
  logic [19:0]           c9;
  logic [9:0]            fold1;
  logic [8:0]            fold2;
  logic [7:0]            color;

  assign zoom_eff = (zoom_q == '0) ? 32'd1 : zoom_q;

  always_comb begin
    if (map_y_q) begin
      off        = $signed({{(OFF_W-10){1'b0}}, py_q}) - HALF_Y;
      map_div    = zoom_eff * SIZE_Y;
      center_sel = center_im_q;
    end else begin
      off        = $signed({{(OFF_W-10){1'b0}}, px_q}) - HALF_X;
      map_div    = zoom_eff * SIZE_X;
      center_sel = center_re_q;
    end
    off_mag = off[OFF_W-1] ? OFF_W'(-off) : OFF_W'(off);
  end

  assign map_val = sat_q(W_W'(from_mag(map_neg_q, div_num_q)) + W_W'(center_sel));

  assign dr      = sat_q(W_W'(na_q) - W_W'(a_q));
  assign di      = sat_q(W_W'(nb_q) - W_W'(b_q));
  assign den3    = sat_q(W_W'(t_q) + (W_W'(t_q) <<< 1));
  assign sq_dist = sat_q(W_W'(dd_q) + W_W'(mul_res));
  assign count_inc = 17'(count_q) + 17'd1;

  assign rcp_quo = (div_rem_q == div_den_q - Q_W'(1)) ? div_num_q + 64'd1 : div_num_q;

  // multiplier operands
  always_comb begin
    unique case (step_q)
      STP_AA:  begin op_x = a_q;   op_y = a_q;   end
      STP_BB:  begin op_x = b_q;   op_y = b_q;   end
      STP_SS:  begin op_x = s_q;   op_y = s_q;   end
      STP_AB:  begin op_x = a_q;   op_y = b_q;   end
      STP_AT:  begin op_x = a_q;   op_y = t_q;   end
      STP_BT:  begin op_x = b_q;   op_y = t_q;   end
      STP_NA:  begin op_x = nre_q; op_y = rcp_q; end
      STP_NB:  begin op_x = nim_q; op_y = rcp_q; end
      STP_DR:  begin op_x = dr;    op_y = dr;    end
      STP_DI:  begin op_x = di;    op_y = di;    end
      default: begin op_x = a_q;   op_y = a_q;   end
    endcase
  end

  // partial product: x half mul_cnt[1], y half mul_cnt[0]
  always_comb begin
    pp = (mul_cnt_q[1] ? mx_q[47:24] : mx_q[23:0]) * (mul_cnt_q[0] ? my_q[47:24] : my_q[23:0]);
    unique case (mul_cnt_q)
      2'd0:    pp_sh = 96'(pp);
      2'd3:    pp_sh = 96'(pp) << 48;
      default: pp_sh = 96'(pp) << 24;
    endcase
  end

  assign mul_res = from_mag(mneg_q, acc_q[95:32]);

  assign rem_sh = {div_rem_q, div_num_q[63]};
  assign div_ge = rem_sh >= {1'b0, div_den_q};

  // color level: (count*9) mod 255, folded on 256 = 1 mod 255
  always_comb begin
    c9    = (20'(count_q) << 3) + 20'(count_q);
    fold1 = 10'(c9[19:16]) + 10'(c9[15:8]) + 10'(c9[7:0]);
    fold2 = 9'(fold1[9:8]) + 9'(fold1[7:0]);
    color = (fold2 >= 9'd255) ? 8'(fold2 - 9'd255) : fold2[7:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE:      if (s_axis_tvalid) state_d = ST_MAP_SETUP;
      ST_MAP_SETUP: state_d = ST_MAP_DIV;
      ST_MAP_DIV:   if (div_cnt_q == '0) state_d = ST_MAP_WB;
      ST_MAP_WB:    state_d = map_y_q ? ST_HEAD : ST_MAP_SETUP;
      ST_HEAD: begin
        if (count_inc >= 17'(max_iter_q)) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_MUL_LOAD;
          step_d  = STP_AA;
        end
      end
      ST_MUL_LOAD:  state_d = ST_MUL_RUN;
      ST_MUL_RUN:   if (mul_cnt_q == 2'd3) state_d = ST_MUL_WB;
      ST_MUL_WB: begin
        state_d = ST_MUL_LOAD;
        unique case (step_q)
          STP_AA: step_d = STP_BB;
          STP_BB: step_d = STP_SS;
          STP_SS: begin
            if (mul_res == '0) state_d = ST_DONE;
            else step_d = STP_AB;
          end
          STP_AB: step_d = STP_AT;
          STP_AT: step_d = STP_BT;
          STP_BT: state_d = ST_RCP_SETUP;
          STP_NA: step_d = STP_NB;
          STP_NB: step_d = STP_DR;
          STP_DR: step_d = STP_DI;
          STP_DI: state_d = (sq_dist <= EPS_Q) ? ST_DONE : ST_HEAD;
          default: state_d = ST_IDLE;
        endcase
      end
      ST_RCP_SETUP: begin
        if ($unsigned(den3) <= RCP_MIN_DEN) begin
          state_d = ST_MUL_LOAD;
          step_d  = STP_NA;
        end else begin
          state_d = ST_RCP_DIV;
        end
      end
      ST_RCP_DIV:   if (div_cnt_q == '0) state_d = ST_RCP_WB;
      ST_RCP_WB: begin
        state_d = ST_MUL_LOAD;
        step_d  = STP_NA;
      end
      ST_DONE:      if (m_axis_tready) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    m_axis_tvalid = (state_q == ST_DONE);
    m_axis_tdata  = {color, count_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= STP_AA;
      map_y_q   <= 1'b0;
      count_q   <= '0;
      div_cnt_q <= '0;
      mul_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      unique case (state_q)
        ST_IDLE: begin
          map_y_q <= 1'b0;
          count_q <= '0;
        end
        ST_MAP_SETUP, ST_RCP_SETUP: div_cnt_q <= 6'd63;
        ST_MAP_DIV, ST_RCP_DIV:     div_cnt_q <= div_cnt_q - 6'd1;
        ST_MAP_WB:   map_y_q   <= 1'b1;
        ST_HEAD:     count_q   <= count_inc[15:0];
        ST_MUL_LOAD: mul_cnt_q <= '0;
        ST_MUL_RUN:  mul_cnt_q <= mul_cnt_q + 2'd1;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        px_q <= s_axis_tdata[9:0];
        py_q <= s_axis_tdata[19:10];
      end
      ST_MAP_SETUP: begin
        map_neg_q <= off[OFF_W-1];
        div_num_q <= 64'(off_mag) << 50;
        div_rem_q <= '0;
        div_den_q <= Q_W'(map_div);
      end
      ST_MAP_DIV, ST_RCP_DIV: begin
        div_rem_q <= div_ge ? Q_W'(rem_sh - {1'b0, div_den_q}) : Q_W'(rem_sh);
        div_num_q <= {div_num_q[62:0], div_ge};
      end
      ST_MAP_WB: begin
        if (map_y_q) b_q <= map_val;
        else a_q <= map_val;
      end
      ST_MUL_LOAD: begin
        mx_q   <= mag_q(op_x);
        my_q   <= mag_q(op_y);
        mneg_q <= op_x[Q_W-1] ^ op_y[Q_W-1];
        acc_q  <= '0;
      end
      ST_MUL_RUN: acc_q <= acc_q + pp_sh;
      ST_MUL_WB: begin
        unique case (step_q)
          STP_AA: aa_q <= mul_res;
          STP_BB: begin
            bb_q <= mul_res;
            s_q  <= sat_q(W_W'(aa_q) + W_W'(mul_res));
          end
          STP_SS: t_q  <= mul_res;
          STP_AB: ab_q <= mul_res;
          STP_AT: nre_q <= sat_q((W_W'(mul_res) <<< 1) + W_W'(aa_q) - W_W'(bb_q));
          STP_BT: nim_q <= sat_q((W_W'(mul_res) <<< 1) - (W_W'(ab_q) <<< 1));
          STP_NA: na_q <= mul_res;
          STP_NB: nb_q <= mul_res;
          STP_DR: dd_q <= mul_res;
          STP_DI: begin
            a_q <= na_q;
            b_q <= nb_q;
          end
          default: ;
        endcase
      end
      ST_RCP_SETUP: begin
        rcp_q     <= QMAX;
        div_num_q <= '1;
        div_rem_q <= '0;
        div_den_q <= $unsigned(den3);
      end
      ST_RCP_WB: rcp_q <= from_mag(1'b0, rcp_quo);
      default: ;
    endcase
  end

  `NFP_ASSERT_NOW(a_one_side, m_axis_tvalid, !s_axis_tready, "input open while result pending")
  `NFP_ASSERT_NEXT(a_start, s_axis_tvalid && s_axis_tready, state_q == ST_MAP_SETUP, "accept did not start mapping")
  `NFP_ASSERT_NOW(a_count_nz, m_axis_tvalid, count_q != '0, "result with zero count")
  `NFP_ASSERT_NOW(a_mul_seq, state_q == ST_MUL_WB, $past(state_q) == ST_MUL_RUN && $past(mul_cnt_q) == 2'd3, "multiplier writeback out of sequence")

endmodule
